// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that must hold at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true at a clock edge outside reset.
`define CHK_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

// ===== sv/bpa_pkg.sv =====
// Types and constants of the bitmap page allocator.
// No dependencies.
package bpa_pkg;
   localparam int Pages = 4096;
   localparam int PageBytes = 4096;
   localparam int PagesPerWord = 8;
   localparam int Words = (Pages + PagesPerWord - 1) / PagesPerWord;
   localparam int PageBits = $clog2(Pages);
   localparam int WordBits = $clog2(Words);
   localparam int LaneBits = $clog2(PagesPerWord);
   localparam int ShiftBits = $clog2(PageBytes);
   localparam int CountBits = PageBits + 1;

   localparam logic [1:0] KindAlloc = 2'd0;
   localparam logic [1:0] KindFree = 2'd1;
   localparam logic [1:0] KindQuery = 2'd2;
   localparam logic [1:0] KindMark = 2'd3;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusNoMem = 2'd1;
   localparam logic [1:0] StatusBadBuf = 2'd2;
   localparam logic [1:0] StatusBadPage = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] address;
      logic [31:0] size_bytes;
      logic [7:0]  page_flags_in;
      logic [11:0] page_index;
      logic        used;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] start_address;
      logic [24:0] granted_bytes;
      logic        is_allocated;
      logic [7:0]  page_flags_out;
   } rsp_type;
endpackage

// ===== sv/bitmap_page_allocator.sv =====
// Bitmap page allocator: one item at a time, one page visited at a time.
// Alloc scans pages for a free run, sets each page of the run and then, if the run
// began at the hint, moves the hint on to the next free page; free clears its pages
// one by one; mark and query visit one page. The page walk over the bitmap memory
// (one read port) sets the pace; a new item is taken only once the previous response
// has been accepted. Reset clears the bitmap one word a cycle, during which no transaction is taken.
module bitmap_page_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bpa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bpa_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [12:0]       csr_data
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD, S_WAIT, S_EVAL, S_SET, S_HINT_RD, S_HINT_WAIT,
      S_HINT_EVAL, S_FLAG, S_DONE
   } state_type;

   state_type state_ff;
   logic [12:0] piu_ff;
   bpa_pkg::req_type req_ff;
   bpa_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic [bpa_pkg::PageBits-1:0] hint_ff;
   logic free_seen_ff;
   logic [bpa_pkg::CountBits-1:0] j_ff, run_ff, first_ff, cnt_ff;
   logic [20:0] n_ff;
   logic [bpa_pkg::WordBits-1:0] clr_ff;

   // Bitmap and flag memories.
   logic [bpa_pkg::PagesPerWord-1:0] bitmap_mem [bpa_pkg::Words];
   logic [7:0] flag_mem [bpa_pkg::Pages];
   logic [bpa_pkg::PagesPerWord-1:0] word_rd_ff;
   logic [7:0] flag_rd_ff;
   logic bm_we;
   logic [bpa_pkg::WordBits-1:0] bm_waddr, bm_raddr;
   logic [bpa_pkg::PagesPerWord-1:0] bm_wdata;
   logic fl_we;
   logic [bpa_pkg::PageBits-1:0] fl_waddr;

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bitmap_mem[bm_waddr] <= bm_wdata;
      end
      word_rd_ff <= bitmap_mem[bm_raddr];
      if (fl_we) begin
         flag_mem[fl_waddr] <= req_ff.page_flags_in;
      end
      flag_rd_ff <= flag_mem[req_ff.page_index];
   end

   // Derived values.
   logic [bpa_pkg::CountBits-1:0] bound;
   logic [bpa_pkg::PageBits-1:0] jp;
   logic cur_bit;
   logic [bpa_pkg::LaneBits-1:0] lane;
   logic [bpa_pkg::CountBits-1:0] sp;
   logic [32:0] sz_round;
   logic [20:0] n_in;
   assign bound = (piu_ff < 13'(bpa_pkg::Pages)) ? bpa_pkg::CountBits'(piu_ff)
                                                : bpa_pkg::CountBits'(bpa_pkg::Pages);
   assign jp = j_ff[bpa_pkg::PageBits-1:0];
   assign lane = jp[bpa_pkg::LaneBits-1:0];
   assign cur_bit = word_rd_ff[lane];
   assign sp = bpa_pkg::CountBits'(req_ff.address >> bpa_pkg::ShiftBits);
   assign sz_round = {1'b0, req_data.size_bytes} + 33'(bpa_pkg::PageBytes - 1);
   assign n_in = 21'(sz_round >> bpa_pkg::ShiftBits);

   logic n_big;
   assign n_big = n_ff > 21'(bound);

   // Memory port control.
   always_comb begin
      bm_we = 1'b0;
      bm_waddr = jp[bpa_pkg::PageBits-1:bpa_pkg::LaneBits];
      bm_raddr = jp[bpa_pkg::PageBits-1:bpa_pkg::LaneBits];
      bm_wdata = word_rd_ff;
      fl_we = 1'b0;
      fl_waddr = jp;
      unique case (state_ff)
         S_CLEAR: begin
            bm_we = 1'b1;
            bm_waddr = clr_ff;
            bm_wdata = '0;
         end
         S_EVAL: begin
            if (req_ff.kind == bpa_pkg::KindMark) begin
               bm_we = 1'b1;
               bm_wdata[lane] = req_ff.used;
               fl_we = req_ff.used;
            end else if (req_ff.kind == bpa_pkg::KindFree && cur_bit) begin
               bm_we = 1'b1;
               bm_wdata[lane] = 1'b0;
            end
         end
         S_SET: begin
            bm_we = 1'b1;
            bm_wdata[lane] = 1'b1;
            fl_we = 1'b1;
         end
         default: ;
      endcase
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         piu_ff <= '0;
         hint_ff <= '0;
         free_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            piu_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == bpa_pkg::WordBits'(bpa_pkg::Words - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid && !rsp_valid_ff) begin
                  req_ff <= req_data;
                  n_ff <= n_in;
                  rsp_ff <= '0;
                  run_ff <= '0;
                  cnt_ff <= '0;
                  first_ff <= bpa_pkg::CountBits'(hint_ff);
                  j_ff <= (req_data.kind == bpa_pkg::KindAlloc)
                          ? bpa_pkg::CountBits'(hint_ff)
                          : (req_data.kind == bpa_pkg::KindFree)
                          ? bpa_pkg::CountBits'(req_data.address >> bpa_pkg::ShiftBits)
                          : bpa_pkg::CountBits'(req_data.page_index);
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               priority if (req_ff.kind == bpa_pkg::KindAlloc &&
                            (n_ff == '0 || n_big)) begin
                  rsp_ff.status <= bpa_pkg::StatusNoMem;
                  state_ff <= S_DONE;
               end else if (req_ff.kind == bpa_pkg::KindFree && n_big) begin
                  rsp_ff.status <= bpa_pkg::StatusNoMem;
                  state_ff <= S_DONE;
               end else if (req_ff.kind != bpa_pkg::KindQuery &&
                            req_ff.kind != bpa_pkg::KindMark && j_ff >= bound) begin
                  rsp_ff.status <= (req_ff.kind == bpa_pkg::KindAlloc)
                                   ? bpa_pkg::StatusNoMem : bpa_pkg::StatusBadBuf;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: state_ff <= S_EVAL;
            S_EVAL: begin
               unique case (req_ff.kind)
                  bpa_pkg::KindAlloc: begin
                     if (cur_bit) begin
                        run_ff <= '0;
                        first_ff <= j_ff + 1'b1;
                        j_ff <= j_ff + 1'b1;
                        state_ff <= S_RD;
                     end else if (21'(run_ff) + 21'd1 == n_ff) begin
                        j_ff <= first_ff;
                        cnt_ff <= '0;
                        state_ff <= S_HINT_RD;
                        rsp_ff.start_address <= 24'(32'(first_ff) * bpa_pkg::PageBytes);
                        rsp_ff.granted_bytes <= 25'({n_ff, {bpa_pkg::ShiftBits{1'b0}}});
                     end else begin
                        run_ff <= run_ff + 1'b1;
                        j_ff <= j_ff + 1'b1;
                        state_ff <= S_RD;
                     end
                  end
                  bpa_pkg::KindFree: begin
                     if (cur_bit && 21'(cnt_ff) + 21'd1 == n_ff) begin
                        rsp_ff.granted_bytes <= 25'({n_ff, {bpa_pkg::ShiftBits{1'b0}}});
                        if (bpa_pkg::CountBits'(hint_ff) > sp) begin
                           hint_ff <= sp[bpa_pkg::PageBits-1:0];
                        end
                        state_ff <= S_DONE;
                     end else begin
                        cnt_ff <= cnt_ff + 1'b1;
                        j_ff <= j_ff + 1'b1;
                        state_ff <= S_RD;
                     end
                  end
                  bpa_pkg::KindQuery: begin
                     rsp_ff.is_allocated <= cur_bit;
                     if (13'(req_ff.page_index) <= piu_ff) begin
                        rsp_ff.start_address <= 24'(32'(req_ff.page_index) *
                                                    bpa_pkg::PageBytes);
                     end
                     state_ff <= S_FLAG;
                  end
                  default: begin
                     if (!req_ff.used && !free_seen_ff) begin
                        hint_ff <= req_ff.page_index;
                        free_seen_ff <= 1'b1;
                     end
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_HINT_RD: begin
               // Read-modify-write of one page of the run per pass.
               if (21'(cnt_ff) == n_ff) begin
                  if (first_ff == bpa_pkg::CountBits'(hint_ff)) begin
                     state_ff <= S_HINT_WAIT;
                  end else begin
                     state_ff <= S_DONE;
                  end
                  j_ff <= bpa_pkg::CountBits'(hint_ff);
                  cnt_ff <= '1;
               end else begin
                  state_ff <= S_HINT_WAIT;
               end
            end
            S_HINT_WAIT: state_ff <= (cnt_ff == '1) ? S_HINT_EVAL : S_SET;
            S_SET: begin
               cnt_ff <= cnt_ff + 1'b1;
               j_ff <= j_ff + 1'b1;
               state_ff <= S_HINT_RD;
            end
            S_HINT_EVAL: begin
               // Advance the hint to the first free page below bound.
               if (j_ff >= bound) begin
                  state_ff <= S_DONE;
               end else if (!cur_bit) begin
                  hint_ff <= jp;
                  state_ff <= S_DONE;
               end else begin
                  j_ff <= j_ff + 1'b1;
                  state_ff <= S_HINT_RD;
               end
            end
            S_FLAG: begin
               rsp_ff.page_flags_out <= flag_rd_ff;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== sv/bpa_checker.sv =====
// Port-level checks of the bitmap page allocator, bound to its top level.
// Depends on assert_macros.svh and bpa_pkg.
`include "assert_macros.svh"
module bpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bpa_pkg::rsp_type rsp_data
);
   // A stalled response holds.
   `CHK_IMPLY(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response dropped or changed")
   // No new request is taken while a response waits.
   `CHK_NEVER(a_one_item, clock, reset, rsp_valid && req_ready, "request taken while busy")
   // A request never returns a response in the next cycle.
   `CHK_IMPLY(a_min_lat, clock, reset, req_valid && req_ready |=> !rsp_valid, "response too early")
endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
